/* hdl/assert_macros.svh */
// Assertion macros shared by the vignette scaler RTL.
// Depends on nothing; the bodies are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RVS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define RVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RVS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RVS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/rvs_pkg.sv */
// Types, widths and the square-root step function of the vignette scaler.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rvs_pkg;

  localparam int POS_W       = 12;
  localparam int DIM_W       = 13;
  localparam int CHAN_W      = 8;
  localparam int RAD_W       = 42;
  localparam int ROOT_W      = 21;
  localparam int REM_W       = 24;
  localparam int Q_W         = 16;
  localparam int GAIN_W      = 18;
  localparam int SIDE_W      = 3 * CHAN_W;
  localparam int SQRT_STEPS  = 3;
  localparam int SQRT_STAGES = 7;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = 4;
  localparam int DEF_MAX_DIM = 4096;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd480;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 18'd65536;
  localparam logic [GAIN_W-1:0] GAIN_TWO   = 18'd131072;
  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } rvs_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } rvs_out_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  // One digit of the bit-pair square root: bring down two radicand bits and
  // try to subtract the trial divisor.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    sqrt_acc_t r;
    rs    = {a.rem[REM_W-3:0], pair};
    trial = {1'b0, a.root, 2'b01};
    if (rs >= trial) begin
      r.rem  = rs - trial;
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/rvs_sqrt_pipe.sv */
// Pipelined integer square root, several digits per register stage.
// Depends on rvs_pkg for widths and the digit step.
`default_nettype none
module rvs_sqrt_pipe import rvs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [RAD_W-1:0]  in_rad,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [ROOT_W-1:0]      out_root,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld  [SQRT_STAGES+1];
  logic [RAD_W-1:0]  rad  [SQRT_STAGES+1];
  sqrt_acc_t         acc  [SQRT_STAGES+1];
  logic [SIDE_W-1:0] side [SQRT_STAGES+1];

  assign vld[0]  = in_vld;
  assign rad[0]  = in_rad;
  assign acc[0]  = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_acc_t        acc_next;
    logic [RAD_W-1:0] rad_next;

    always_comb begin
      acc_next = acc[s];
      rad_next = rad[s];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        acc_next = sqrt_step(acc_next, rad_next[RAD_W-1 -: 2]);
        rad_next = {rad_next[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        acc[s+1]  <= acc_next;
        rad[s+1]  <= rad_next;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_vld  = vld[SQRT_STAGES];
  assign out_root = acc[SQRT_STAGES].root;
  assign out_side = side[SQRT_STAGES];

endmodule
`default_nettype wire

/* hdl/rvs_div_pipe.sv */
// Pipelined restoring divider giving the Q16 fraction d/m for d below m.
// Depends on rvs_pkg for widths.
`default_nettype none
module rvs_div_pipe import rvs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [ROOT_W-1:0]   in_num,
  input  wire logic [ROOT_W-1:0]   divisor,
  input  wire logic [SIDE_W+1:0]   in_side,
  output logic                     out_vld,
  output logic [Q_W-1:0]           out_quot,
  output logic [SIDE_W+1:0]        out_side
);

  logic              vld  [DIV_STAGES+1];
  logic [ROOT_W-1:0] rem  [DIV_STAGES+1];
  logic [Q_W-1:0]    quot [DIV_STAGES+1];
  logic [SIDE_W+1:0] side [DIV_STAGES+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = in_num;
  assign quot[0] = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [ROOT_W-1:0] rem_next;
    logic [Q_W-1:0]    quot_next;

    always_comb begin
      logic [ROOT_W:0] rem2;
      rem_next  = rem[s];
      quot_next = quot[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem2 = {rem_next, 1'b0};
        if (rem2 >= {1'b0, divisor}) begin
          rem_next  = ROOT_W'(rem2 - {1'b0, divisor});
          quot_next = {quot_next[Q_W-2:0], 1'b1};
        end else begin
          rem_next  = rem2[ROOT_W-1:0];
          quot_next = {quot_next[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        rem[s+1]  <= rem_next;
        quot[s+1] <= quot_next;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_vld  = vld[DIV_STAGES];
  assign out_quot = quot[DIV_STAGES];
  assign out_side = side[DIV_STAGES];

endmodule
`default_nettype wire

/* hdl/radial_vignette_scaler.sv */
// Top level of the radial vignette scaler: offsets, square-root and divider
// pipelines, gain and channel scaling. Depends on rvs_pkg, rvs_sqrt_pipe,
// rvs_div_pipe and assert_macros.svh.
//
//   channel   direction  handshake             payload
//   in        into block in_valid / in_stall   rvs_in_t  (pos_x, pos_y, rgb)
//   out       from block out_valid / out_stall rvs_out_t (scaled rgb)
//   cfg       into block cfg_valid / cfg_ready cfg_index, cfg_data
//
// A pixel passes stages 1 and 2, the seven square-root and four divider
// stages, the gain stage and the output register; one pixel is taken
// every cycle while in_stall is low.
// After reset and after each configuration write the corner distance is
// recomputed one root digit a cycle, with in_stall high until it is done.
// The whole pipeline holds while a result waits under out_stall.
`default_nettype none
`include "assert_macros.svh"
module radial_vignette_scaler import rvs_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rvs_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rvs_out_t              out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int SQ_W  = 2 * POS_W + 1;

  logic              en;
  logic              busy;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [DIM_W-1:0]  cfg_sat;
  logic [POS_W-1:0]  cx;
  logic [POS_W-1:0]  cy;

  // Corner distance, worked out serially.
  logic              m_load;
  logic [CNT_W-1:0]  m_cnt;
  logic [RAD_W-1:0]  m_rad;
  sqrt_acc_t         m_acc;
  logic [ROOT_W-1:0] corner;

  assign en        = !out_valid || !out_stall;
  assign busy      = m_load || (m_cnt != '0);
  assign in_stall  = !en || busy;
  assign cfg_ready = !busy;
  assign cx        = image_width[DIM_W-1:1];
  assign cy        = image_height[DIM_W-1:1];
  assign corner    = m_acc.root;
  assign cfg_sat   = ({19'b0, cfg_data} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      m_load       <= 1'b1;
      m_cnt        <= '0;
    end else begin
      m_load <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        m_load <= 1'b1;
        if (cfg_index == REG_WIDTH) begin
          image_width <= cfg_sat;
        end else begin
          image_height <= cfg_sat;
        end
      end
      if (m_load) begin
        m_cnt <= CNT_W'(ROOT_W);
      end else if (m_cnt != '0) begin
        m_cnt <= m_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_rad <= {(RAD_W-16)'(32'(cx) * 32'(cx) + 32'(cy) * 32'(cy)), 16'b0};
      m_acc <= '0;
    end else if (m_cnt != '0) begin
      m_acc <= sqrt_step(m_acc, m_rad[RAD_W-1 -: 2]);
      m_rad <= {m_rad[RAD_W-3:0], 2'b00};
    end
  end

  // Stage 1: offsets from the centre.
  logic              s1_vld;
  logic [POS_W-1:0]  s1_dx;
  logic [POS_W-1:0]  s1_dy;
  logic [SIDE_W-1:0] s1_rgb;

  // Stage 2: squared distance.
  logic              s2_vld;
  logic [2*POS_W:0]  s2_sum;
  logic [SIDE_W-1:0] s2_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid && !in_stall;
      s2_vld <= s1_vld;
    end
    if (en) begin
      s1_dx  <= (in_data.pos_x >= cx) ? in_data.pos_x - cx : cx - in_data.pos_x;
      s1_dy  <= (in_data.pos_y >= cy) ? in_data.pos_y - cy : cy - in_data.pos_y;
      s1_rgb <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      s2_sum <= SQ_W'(s1_dx) * SQ_W'(s1_dx) + SQ_W'(s1_dy) * SQ_W'(s1_dy);
      s2_rgb <= s1_rgb;
    end
  end

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_rgb;

  rvs_sqrt_pipe u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s2_vld),
    .in_rad  ({RAD_W'({s2_sum, 16'b0})}),
    .in_side (s2_rgb),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_side(sq_rgb)
  );

  // A distance at or past the corner gives a ratio of one or more: gain zero (gain one if the corner is 0).
  logic              dv_vld;
  logic [Q_W-1:0]    dv_quot;
  logic [SIDE_W+1:0] dv_side;

  rvs_div_pipe u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (sq_vld),
    .in_num  (sq_root),
    .divisor (corner),
    .in_side ({corner == '0, sq_root >= corner, sq_rgb}),
    .out_vld (dv_vld),
    .out_quot(dv_quot),
    .out_side(dv_side)
  );

  // Gain stage.
  logic              g_vld;
  logic [GAIN_W-1:0] g_gain;
  logic [SIDE_W-1:0] g_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= dv_vld;
    end
    if (en) begin
      g_rgb <= dv_side[SIDE_W-1:0];
      if (dv_side[SIDE_W+1]) begin
        g_gain <= GAIN_ONE;
      end else if (dv_side[SIDE_W]) begin
        g_gain <= '0;
      end else begin
        g_gain <= GAIN_TWO - {1'b0, dv_quot, 1'b0};
      end
    end
  end

  function automatic logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] c,
                                                   logic [GAIN_W-1:0] g);
    logic [CHAN_W+GAIN_W-1:0] p;
    p = {{GAIN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, g};
    return (p[CHAN_W+GAIN_W-1:16] > {2'b0, CHAN_MAX}) ? CHAN_MAX : p[23:16];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= g_vld;
    end
    if (en) begin
      out_data.red_out   <= scale_chan(g_rgb[23:16], g_gain);
      out_data.green_out <= scale_chan(g_rgb[15:8], g_gain);
      out_data.blue_out  <= scale_chan(g_rgb[7:0], g_gain);
    end
  end

  `RVS_ASSERT_IMPL(a_busy_stalls, clk, rst, busy, in_stall && !cfg_ready)
  `RVS_ASSERT_NEXT(a_cfg_starts, clk, rst, cfg_valid && cfg_ready, busy)
  `RVS_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid)

endmodule
`default_nettype wire

/* tb/sv/rvs_checker.sv */
// Checker for the radial vignette scaler: watches the pixel, result and
// register channels, predicts every result and compares it on arrival.
// Depends on rvs_pkg.
module rvs_checker import rvs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire rvs_in_t          in_data,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire rvs_out_t         out_data,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DIM_W-1:0] frame_w, frame_h;
  rvs_out_t scaled_q[$];

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [CHAN_W-1:0] apply_gain(logic [CHAN_W-1:0] c,
                                                   logic [63:0] gain);
    logic [63:0] v;
    v = (64'(c) * gain) >> 16;
    return (v > 255) ? CHAN_MAX : v[CHAN_W-1:0];
  endfunction

  function automatic rvs_out_t vignette(rvs_in_t p);
    logic [63:0] cx, cy, dx, dy, radius, corner, ratio, gain;
    rvs_out_t o;
    cx = 64'(frame_w >> 1);
    cy = 64'(frame_h >> 1);
    dx = (p.pos_x >= cx) ? p.pos_x - cx : cx - p.pos_x;
    dy = (p.pos_y >= cy) ? p.pos_y - cy : cy - p.pos_y;
    radius = root_floor((dx * dx + dy * dy) << 16);
    corner = root_floor((cx * cx + cy * cy) << 16);
    if (corner == 0) begin
      gain = 65536;
    end else begin
      ratio = (radius << 16) / corner;
      gain = (ratio >= 65536) ? 0 : 131072 - 2 * ratio;
    end
    o.red_out = apply_gain(p.red_in, gain);
    o.green_out = apply_gain(p.green_in, gain);
    o.blue_out = apply_gain(p.blue_in, gain);
    return o;
  endfunction

  always @(posedge clk) begin
    rvs_out_t want;
    logic [DIM_W-1:0] v;
    if (rst) begin
      frame_w <= RST_WIDTH;
      frame_h <= RST_HEIGHT;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) scaled_q = {scaled_q, vignette(in_data)};
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = scaled_q.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch, expected r%0d g%0d b%0d, actual r%0d g%0d b%0d",
                     $time, want.red_out, want.green_out, want.blue_out,
                     out_data.red_out, out_data.green_out, out_data.blue_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= scaled_q.size();
      if (cfg_valid && cfg_ready) begin
        v = (cfg_data > DEF_MAX_DIM) ? DIM_W'(DEF_MAX_DIM) : cfg_data;
        if (cfg_index == REG_WIDTH) frame_w <= v;
        else frame_h <= v;
      end
    end
  end
endmodule

/* tb/sv/tb_top.sv */
// Top of the vignette scaler testbench: clock, reset, pixel and register
// stimulus, receiver stalls and the verdict. Depends on rvs_pkg and rvs_checker.
module tb_top import rvs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  rvs_in_t in_data;
  rvs_out_t out_data;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [DIM_W-1:0] cfg_data;
  int fail_count, pending;
  int stall_pct;
  bit hold_long;

  radial_vignette_scaler u_dut (.*);
  rvs_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, a calm stretch and one long hold-off.
  initial begin
    out_stall = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (120) @(negedge clk);
        out_stall <= 0;
        wait (!hold_long);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Leaves in_valid high; a gap in the next transaction or the drain lowers it.
  task automatic send_pixel(rvs_in_t p, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic rvs_in_t pick_pixel(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    rvs_in_t p;
    p = rvs_in_t'(48'({$urandom, $urandom}));
    // Mostly inside the frame; the rest anywhere, including beyond the corner.
    if ($urandom_range(9) < 8) begin
      p.pos_x = (w > 0) ? POS_W'($urandom_range(w - 1)) : '0;
      p.pos_y = (h > 0) ? POS_W'($urandom_range(h - 1)) : '0;
    end
    return p;
  endfunction

  initial begin
    logic [DIM_W-1:0] ws[6] = '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd37};
    logic [DIM_W-1:0] hs[6] = '{13'd480, 13'd1, 13'd4096, 13'd5000, 13'd2, 13'd300};
    logic [DIM_W-1:0] w, h;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    stall_pct = 36;
    hold_long = 0;
    repeat (8) @(negedge clk);
    rst <= 0;

    // Directed pixels under the reset frame of 640 by 480.
    send_pixel('{12'd320, 12'd240, 8'd255, 8'd128, 8'd1}, 0);
    send_pixel('{12'd0, 12'd0, 8'd255, 8'd255, 8'd255}, 0);
    send_pixel('{12'd639, 12'd479, 8'd200, 8'd0, 8'd77}, 0);
    send_pixel('{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255}, 0);
    send_pixel('{12'd321, 12'd240, 8'd0, 8'd0, 8'd0}, 0);
    send_pixel('{12'd100, 12'd400, 8'd170, 8'd85, 8'd255}, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      w = ws[ph];
      h = hs[ph];
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      if (w > DEF_MAX_DIM) w = DIM_W'(DEF_MAX_DIM);
      if (h > DEF_MAX_DIM) h = DIM_W'(DEF_MAX_DIM);
      // One directed centre and one corner pixel for every frame size.
      send_pixel('{POS_W'(w >> 1), POS_W'(h >> 1), 8'd255, 8'd255, 8'd255}, 0);
      send_pixel('{12'd0, 12'd0, 8'd255, 8'd1, 8'd128}, 0);
      stall_pct = (ph == 2) ? 0 : 36;
      for (int i = 0; i < 135; i++) begin
        if (ph == 1 && i == 20) hold_long = 1;
        if (ph == 1 && i == 80) hold_long = 0;
        send_pixel(pick_pixel(w, h), (ph == 2) ? 0 : 36);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/rvs_pkg.sv
hdl/rvs_sqrt_pipe.sv
hdl/rvs_div_pipe.sv
hdl/radial_vignette_scaler.sv
tb/sv/rvs_checker.sv
tb/sv/tb_top.sv
